[hw/rtl/multi_text_buffer_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// Multi text buffer engine assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_TEXT_BUFFER_ENGINE_TOP_DEFINES_SVH
`define MULTI_TEXT_BUFFER_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define MTBE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtbe check failed");

// next-cycle implication
`define MTBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtbe check failed");

`endif

[hw/rtl/mtbe_pkg.sv]
// ----------------------------------------------------------------------------
// Multi text buffer engine package
// Request codes, status codes, stream widths and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mtbe_pkg;

   localparam int REQ_TYPE_W   = 3;
   localparam int BUF_ID_W     = 3;
   localparam int POSITION_W   = 16;
   localparam int CHAR_W       = 8;
   localparam int ALLOC_SIZE_W = 16;
   localparam int STATUS_W     = 2;
   localparam int READ_VALUE_W = 17;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = REQ_TYPE_W;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = STATUS_W;

   localparam logic [READ_VALUE_W-1:0] VAL_NONE = '1;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_ALLOC     = 3'd0,
      OP_INSERT    = 3'd1,
      OP_DELETE    = 3'd2,
      OP_CLEAR     = 3'd3,
      OP_SIZE      = 3'd4,
      OP_READ_CHAR = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IGNORED  = 2'd0,
      ST_ACCEPTED = 2'd1,
      ST_OOM      = 2'd2
   } status_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic shift;
      logic put;
      logic read;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic go_shift;
      logic go_put;
      logic go_read;
      logic shift_done;
      logic is_insert;
      logic out_free;
   } ctrl_sts_type;

endpackage

`default_nettype wire

[hw/rtl/multi_text_buffer_engine_top.sv]
// ----------------------------------------------------------------------------
// Multi text buffer engine
// NUM_BUFFERS byte text buffers with alloc, insert, delete, clear, size and
// character read requests; one response per request.
//
//   channel  direction  tdata                                        tuser
//   req      in         buf_id, position, char_in, alloc_size        req_type
//   rsp      out        read_value                                   status
//
// One request at a time: accept and decode, one tail move step per byte moved
// and one more to close the move, then the insert byte write or the character
// read, then the response. The longest is an insert at the front of a buffer
// one short of full. The tail move runs one byte per cycle through the
// character memory. Reset clears allocation, length and capacity; the
// character memory is not cleared. A new request is taken while a response
// waits; the engine holds before its response slot until rsp_tready frees it.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_text_buffer_engine_top #(
   parameter int NUM_BUFFERS = 4,
   parameter int MAX_LEN     = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // buf_id[2:0], position[18:3], char_in[26:19], alloc_size[42:27], zero pad
   input  logic [mtbe_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[2:0]
   input  logic [mtbe_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_value[16:0], zero pad
   output logic [mtbe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [mtbe_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mtbe_pkg::*;

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   mtbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mtbe_datapath #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .MAX_LEN     (MAX_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[hw/rtl/mtbe_ctrl.sv]
// ----------------------------------------------------------------------------
// Multi text buffer engine controller
// Sequences one request: decode, tail shift, byte write or read, response.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mtbe_pkg::ctrl_sts_type sts,
   output mtbe_pkg::ctrl_cmd_type cmd
);
   import mtbe_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_SHIFT = 6'b000100,
      S_PUT   = 6'b001000,
      S_READ  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.go_shift) state_in = S_SHIFT;
            else if (sts.go_put) state_in = S_PUT;
            else if (sts.go_read) state_in = S_READ;
            else state_in = S_RESP;
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) state_in = sts.is_insert ? S_PUT : S_RESP;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_RESP;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

[hw/rtl/mtbe_datapath.sv]
// ----------------------------------------------------------------------------
// Multi text buffer engine datapath
// Request registers, per-buffer length/capacity, character memory with a
// pipelined tail mover, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbe_datapath #(
   parameter int NUM_BUFFERS = 4,
   parameter int MAX_LEN     = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mtbe_pkg::ctrl_cmd_type              cmd,
   output mtbe_pkg::ctrl_sts_type              sts,
   input  logic [mtbe_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [mtbe_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [mtbe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [mtbe_pkg::RSP_USER_W-1:0]     rsp_tuser
);
   import mtbe_pkg::*;

   localparam int LW    = $clog2(MAX_LEN + 1);
   localparam int IDW   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int DEPTH = NUM_BUFFERS * MAX_LEN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // request fields
   logic [REQ_TYPE_W-1:0]         op_ff;
   logic [BUF_ID_W-1:0]           id_ff;
   logic signed [POSITION_W-1:0]  pos_ff;
   logic [CHAR_W-1:0]             ch_ff;
   logic [ALLOC_SIZE_W-1:0]       asize_ff;

   // per-buffer state
   logic          alc_ff [0:NUM_BUFFERS-1];
   logic [LW-1:0] len_ff [0:NUM_BUFFERS-1];
   logic [LW-1:0] cap_ff [0:NUM_BUFFERS-1];

   // tail mover
   logic [LW-1:0] moves_ff, moves_in;
   logic [LW-1:0] rd_off_ff, rd_off_in;
   logic [LW-1:0] wr_off_ff, wr_off_in;
   logic [LW-1:0] put_off_ff;
   logic          dir_up_ff;
   logic          pend_ff, pend_in;

   // memory
   logic [CHAR_W-1:0] mem [0:DEPTH-1];
   logic [CHAR_W-1:0] rdata_ff;
   logic              mem_we, mem_re;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data;

   // result
   logic [STATUS_W-1:0]     res_st_ff;
   logic [READ_VALUE_W-1:0] res_val_ff;
   logic                    use_mem_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_st_ff;
   logic [READ_VALUE_W-1:0] rsp_val_ff;

   // decode
   logic          id_ok;
   logic [IDW-1:0] idx;
   logic          alc;
   logic [LW-1:0] len, cap;
   logic          pos_neg, pos_lt_len, pos_gt_len, full, too_big;
   logic [LW-1:0] ins_p, del_p, ins_moves, del_moves;
   logic          ins_do, del_do, get_rd;
   logic [STATUS_W-1:0]     st_calc;
   logic [READ_VALUE_W-1:0] val_calc;

   function automatic logic [AW-1:0] mem_addr(input logic [IDW-1:0] b,
                                              input logic [LW-1:0] off);
      mem_addr = AW'(int'(b) * MAX_LEN + int'(off));
   endfunction

   always_comb begin
      id_ok      = ({1'b0, id_ff} < 4'(NUM_BUFFERS));
      idx        = id_ok ? id_ff[IDW-1:0] : '0;
      alc        = alc_ff[idx];
      len        = len_ff[idx];
      cap        = cap_ff[idx];
      pos_neg    = pos_ff[POSITION_W-1];
      pos_lt_len = !pos_neg && ({1'b0, pos_ff} < 17'(len));
      pos_gt_len = !pos_neg && ({1'b0, pos_ff} > 17'(len));
      full       = (len >= cap) || (len >= LW'(MAX_LEN));
      too_big    = ({1'b0, asize_ff} > 17'(MAX_LEN));
      ins_p      = pos_neg ? '0 : (pos_gt_len ? len : pos_ff[LW-1:0]);
      del_p      = pos_ff[LW-1:0];
      ins_moves  = len - ins_p;
      del_moves  = len - LW'(1) - del_p;
      ins_do     = (op_ff == OP_INSERT) && id_ok && alc && !full;
      del_do     = (op_ff == OP_DELETE) && id_ok && alc && (len != '0) && pos_lt_len;
      get_rd     = (op_ff == OP_READ_CHAR) && id_ok && alc && pos_lt_len;

      st_calc  = ST_IGNORED;
      val_calc = '0;
      if (id_ok) begin
         unique case (op_ff)
            OP_ALLOC:    st_calc = too_big ? ST_OOM : ST_ACCEPTED;
            OP_INSERT:   if (alc) st_calc = ST_ACCEPTED;
            OP_DELETE:   if (alc && (len != '0)) st_calc = ST_ACCEPTED;
            OP_CLEAR:    if (alc) st_calc = ST_ACCEPTED;
            OP_SIZE: begin
               st_calc  = ST_ACCEPTED;
               val_calc = READ_VALUE_W'(len);
            end
            OP_READ_CHAR: begin
               if (alc) begin
                  st_calc  = ST_ACCEPTED;
                  val_calc = pos_lt_len ? '0 : VAL_NONE;
               end
            end
            default: st_calc = ST_IGNORED;
         endcase
      end
   end

   always_comb begin
      sts.go_shift   = (ins_do && (ins_moves != '0)) || (del_do && (del_moves != '0));
      sts.go_put     = ins_do && (ins_moves == '0);
      sts.go_read    = get_rd;
      sts.shift_done = (moves_ff == '0);
      sts.is_insert  = dir_up_ff;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_tuser;
         id_ff    <= req_tdata[2:0];
         pos_ff   <= req_tdata[18:3];
         ch_ff    <= req_tdata[26:19];
         asize_ff <= req_tdata[42:27];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            alc_ff[i] <= 1'b0;
            len_ff[i] <= '0;
            cap_ff[i] <= '0;
         end
      end else if (cmd.exec && id_ok) begin
         if (op_ff == OP_ALLOC) begin
            if (too_big) begin
               alc_ff[idx] <= 1'b0;
            end else begin
               alc_ff[idx] <= 1'b1;
               cap_ff[idx] <= asize_ff[LW-1:0];
               len_ff[idx] <= '0;
            end
         end else if (ins_do) begin
            len_ff[idx] <= len + LW'(1);
         end else if (del_do) begin
            len_ff[idx] <= len - LW'(1);
         end else if ((op_ff == OP_CLEAR) && alc) begin
            len_ff[idx] <= '0;
         end
      end
   end

   // tail mover: read one slot per cycle, write it one slot over the next cycle
   always_comb begin
      moves_in  = moves_ff;
      rd_off_in = rd_off_ff;
      wr_off_in = wr_off_ff;
      pend_in   = 1'b0;
      if (cmd.exec) begin
         if (ins_do) begin
            moves_in  = ins_moves;
            rd_off_in = len - LW'(1);
         end else if (del_do) begin
            moves_in  = del_moves;
            rd_off_in = del_p + LW'(1);
         end else begin
            moves_in = '0;
         end
      end else if (cmd.shift && (moves_ff != '0)) begin
         pend_in   = 1'b1;
         moves_in  = moves_ff - LW'(1);
         rd_off_in = dir_up_ff ? rd_off_ff - LW'(1) : rd_off_ff + LW'(1);
         wr_off_in = dir_up_ff ? rd_off_ff + LW'(1) : rd_off_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         moves_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         moves_ff <= moves_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_off_ff <= rd_off_in;
      wr_off_ff <= wr_off_in;
      if (cmd.exec) begin
         dir_up_ff  <= (op_ff == OP_INSERT);
         put_off_ff <= ins_p;
         res_st_ff  <= st_calc;
         res_val_ff <= val_calc;
         use_mem_ff <= get_rd;
      end
   end

   always_comb begin
      mem_we  = pend_ff || cmd.put;
      wr_addr = pend_ff ? mem_addr(idx, wr_off_ff) : mem_addr(idx, put_off_ff);
      wr_data = pend_ff ? rdata_ff : ch_ff;
      mem_re  = cmd.read || (cmd.shift && (moves_ff != '0));
      rd_addr = cmd.read ? mem_addr(idx, pos_ff[LW-1:0]) : mem_addr(idx, rd_off_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (mem_re) rdata_ff <= mem[rd_addr];
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_st_ff  <= res_st_ff;
         rsp_val_ff <= use_mem_ff ? READ_VALUE_W'(rdata_ff) : res_val_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - READ_VALUE_W)'(0), rsp_val_ff};
   assign rsp_tuser  = rsp_st_ff;

endmodule

`default_nettype wire

[hw/rtl/mtbe_checker.sv]
// ----------------------------------------------------------------------------
// Multi text buffer engine port checker
// Port-level checks on response codes and request sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_text_buffer_engine_top_defines.svh"

module mtbe_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [mtbe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [mtbe_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mtbe_pkg::*;

   `MTBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   `MTBE_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid, rsp_tuser != 2'd3)

   `MTBE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   `MTBE_ASSERT_IMPL(a_no_value_unless_accepted, clock, reset, rsp_tvalid && (rsp_tuser == ST_IGNORED || rsp_tuser == ST_OOM), rsp_tdata == '0)

endmodule

bind multi_text_buffer_engine_top mtbe_checker u_mtbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[dv/multi_text_buffer_engine_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi text buffer engine checker
// Watches the request and response streams. It keeps its own copy of every
// buffer (allocation, capacity, length, bytes), predicts one response per
// accepted request and compares status and read value in order.
// ----------------------------------------------------------------------------

module multi_text_buffer_engine_checker #(
   parameter int NUM_BUFFERS = 4,
   parameter int MAX_LEN     = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // buf_id[2:0], position[18:3], char_in[26:19], alloc_size[42:27], zero pad
   input  logic [mtbe_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[2:0]
   input  logic [mtbe_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_value[16:0], zero pad
   input  logic [mtbe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   input  logic [mtbe_pkg::RSP_USER_W-1:0] rsp_tuser,
   output int                              fail_count,
   output int                              pending_count,
   output int                              rsp_count,
   output int                              ignored_count,
   output int                              oom_count,
   output int                              peak_length
);

   import mtbe_pkg::*;

   typedef struct packed {
      status_type                st;
      logic [READ_VALUE_W-1:0]   val;
   } text_rsp_type;

   logic [CHAR_W-1:0] text_bytes [NUM_BUFFERS][MAX_LEN];
   logic              buf_alloc  [NUM_BUFFERS];
   int                buf_len    [NUM_BUFFERS];
   int                buf_cap    [NUM_BUFFERS];
   text_rsp_type      expected_rsp [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      rsp_count     = 0;
      ignored_count = 0;
      oom_count     = 0;
      peak_length   = 0;
   end

   task automatic apply_text_op(
      input  logic [REQ_TYPE_W-1:0]   kind,
      input  logic [BUF_ID_W-1:0]     id,
      input  logic signed [15:0]      pos,
      input  logic [CHAR_W-1:0]       ch,
      input  logic [ALLOC_SIZE_W-1:0] asize,
      output text_rsp_type            rsp
   );
      int len;
      int p;
      int i;
      rsp.st  = ST_IGNORED;
      rsp.val = '0;
      if (id < NUM_BUFFERS) begin
         len = buf_len[id];
         p   = int'(pos);
         case (kind)
            OP_ALLOC: begin
               if (asize > MAX_LEN) begin
                  buf_alloc[id] = 1'b0;
                  rsp.st = ST_OOM;
               end else begin
                  buf_alloc[id] = 1'b1;
                  buf_cap[id]   = int'(asize);
                  buf_len[id]   = 0;
                  rsp.st = ST_ACCEPTED;
               end
            end
            OP_INSERT: begin
               if (buf_alloc[id]) begin
                  rsp.st = ST_ACCEPTED;
                  if (len < buf_cap[id] && len < MAX_LEN) begin
                     if (p < 0) p = 0;
                     else if (p > len) p = len;
                     for (i = len; i > p; i--) text_bytes[id][i] = text_bytes[id][i-1];
                     text_bytes[id][p] = ch;
                     buf_len[id] = len + 1;
                     if (len + 1 > peak_length) peak_length = len + 1;
                  end
               end
            end
            OP_DELETE: begin
               if (buf_alloc[id] && len != 0) begin
                  rsp.st = ST_ACCEPTED;
                  if (p >= 0 && p < len) begin
                     for (i = p; i < len - 1; i++) text_bytes[id][i] = text_bytes[id][i+1];
                     buf_len[id] = len - 1;
                  end
               end
            end
            OP_CLEAR: begin
               if (buf_alloc[id]) begin
                  buf_len[id] = 0;
                  rsp.st = ST_ACCEPTED;
               end
            end
            OP_SIZE: begin
               rsp.val = READ_VALUE_W'(len);
               rsp.st  = ST_ACCEPTED;
            end
            OP_READ_CHAR: begin
               if (buf_alloc[id]) begin
                  rsp.st = ST_ACCEPTED;
                  if (p < 0 || p >= len) rsp.val = VAL_NONE;
                  else rsp.val = READ_VALUE_W'(text_bytes[id][p]);
               end
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin : monitor
      text_rsp_type want;
      text_rsp_type got;
      if (reset) begin
         for (int b = 0; b < NUM_BUFFERS; b++) begin
            buf_alloc[b] = 1'b0;
            buf_len[b]   = 0;
            buf_cap[b]   = 0;
         end
         expected_rsp.delete();
      end else begin
         // response first: a response never belongs to a request taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (expected_rsp.size() == 0) begin
               $error("response transaction with no request outstanding: status %0d value %0h",
                      rsp_tuser, rsp_tdata[READ_VALUE_W-1:0]);
               fail_count++;
            end else begin
               want = expected_rsp.pop_front();
               got.st  = status_type'(rsp_tuser);
               got.val = rsp_tdata[READ_VALUE_W-1:0];
               if (want.st == ST_IGNORED) ignored_count++;
               if (want.st == ST_OOM) oom_count++;
               if (rsp_tuser !== want.st) begin
                  $error("status: expected %0d, got %0d", want.st, rsp_tuser);
                  fail_count++;
               end
               if (got.val !== want.val) begin
                  $error("read_value: expected %0h, got %0h", want.val, got.val);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_text_op(req_tuser, req_tdata[2:0], req_tdata[18:3], req_tdata[26:19],
                          req_tdata[42:27], want);
            expected_rsp.push_back(want);
         end
      end
      pending_count = expected_rsp.size();
   end

endmodule

[dv/multi_text_buffer_engine_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi text buffer engine testbench
// Directed corner requests, one buffer filled to MAX_LEN, then random request
// sequences over all buffers with random gaps on both streams. The checker
// beside the engine predicts and compares every response.
// ----------------------------------------------------------------------------

module multi_text_buffer_engine_top_tb;

   import mtbe_pkg::*;

   localparam int NUM_BUFFERS = 4;
   localparam int MAX_LEN     = 256;
   localparam int REQ_TARGET  = 700;
   localparam int STALL_LIMIT = 5000;

   localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_6 = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_RSVD_7 = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int fail_count;
   int pending_count;
   int rsp_count;
   int ignored_count;
   int oom_count;
   int peak_length;

   int   req_sent;
   int   req_useful;
   int   idle_cycles;
   int   rsp_hold;
   logic no_gaps;

   always #10 clock = ~clock;

   multi_text_buffer_engine_top #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .MAX_LEN     (MAX_LEN)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   multi_text_buffer_engine_checker #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .MAX_LEN     (MAX_LEN)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .rsp_count     (rsp_count),
      .ignored_count (ignored_count),
      .oom_count     (oom_count),
      .peak_length   (peak_length)
   );

   // response side backpressure: long ready runs, short stalls, a few long ones
   always @(posedge clock) begin
      int r;
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            rsp_tready <= 1'b1;
            rsp_hold   <= $urandom_range(0, 20);
         end else if (r < 92) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(15, 50);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 50);
   endfunction

   function automatic logic [BUF_ID_W-1:0] pick_buf();
      if ($urandom_range(0, 9) != 0) return BUF_ID_W'($urandom_range(0, NUM_BUFFERS - 1));
      return BUF_ID_W'($urandom_range(NUM_BUFFERS, 7));
   endfunction

   function automatic logic [POSITION_W-1:0] pick_pos();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return POSITION_W'($urandom_range(0, 24));
      if (r < 70) return POSITION_W'($urandom_range(0, MAX_LEN + 44));
      if (r < 85) return POSITION_W'(-$urandom_range(1, 4));
      return POSITION_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [ALLOC_SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return ALLOC_SIZE_W'($urandom_range(0, 24));
      if (r < 75) return ALLOC_SIZE_W'($urandom_range(MAX_LEN - 56, MAX_LEN));
      if (r < 85) return ALLOC_SIZE_W'($urandom_range(MAX_LEN, MAX_LEN + 1));
      return ALLOC_SIZE_W'($urandom_range(0, 65535));
   endfunction

   task automatic send_req(
      input logic [REQ_TYPE_W-1:0]   kind,
      input logic [BUF_ID_W-1:0]     id,
      input logic [POSITION_W-1:0]   pos,
      input logic [CHAR_W-1:0]       ch,
      input logic [ALLOC_SIZE_W-1:0] asize
   );
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, asize, ch, pos, id};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_sent++;
      if (id < NUM_BUFFERS && kind <= OP_READ_CHAR) req_useful++;
   endtask

   task automatic rand_req(input logic [REQ_TYPE_W-1:0] kind, input logic [BUF_ID_W-1:0] id);
      send_req(kind, id, pick_pos(), CHAR_W'($urandom_range(0, 255)),
               ALLOC_SIZE_W'($urandom_range(0, 65535)));
   endtask

   initial begin
      int r;
      int n;
      logic [BUF_ID_W-1:0] id;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      rsp_tready  <= 1'b0;
      rsp_hold    = 0;
      idle_cycles = 0;
      req_sent    = 0;
      req_useful  = 0;
      no_gaps     = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // unallocated buffer, unknown buffer, reserved request codes
      send_req(OP_SIZE,      3'd0, 16'h0000, 8'h00, 16'h0000);
      send_req(OP_INSERT,    3'd0, 16'h0000, 8'h41, 16'h0000);
      send_req(OP_READ_CHAR, 3'd0, 16'h0000, 8'h00, 16'h0000);
      send_req(OP_DELETE,    3'd0, 16'h0000, 8'h00, 16'h0000);
      send_req(OP_CLEAR,     3'd0, 16'h0000, 8'h00, 16'h0000);
      send_req(OP_ALLOC,     3'd7, 16'h0000, 8'h00, 16'h0010);
      send_req(REQ_RSVD_6,   3'd0, 16'hFFFF, 8'hFF, 16'hFFFF);
      send_req(REQ_RSVD_7,   3'd0, 16'h0000, 8'h00, 16'h0000);
      // oversized alloc, zero-size alloc is always full
      send_req(OP_ALLOC,     3'd0, 16'h0000, 8'h00, 16'hFFFF);
      send_req(OP_ALLOC,     3'd0, 16'h0000, 8'h00, 16'(MAX_LEN + 1));
      send_req(OP_ALLOC,     3'd1, 16'h0000, 8'h00, 16'h0000);
      send_req(OP_INSERT,    3'd1, 16'h0000, 8'h5A, 16'h0000);
      send_req(OP_ALLOC,     3'd0, 16'h0000, 8'h00, 16'(MAX_LEN));
      send_req(OP_DELETE,    3'd0, 16'h0000, 8'h00, 16'h0000);
      // insert with clamped positions
      send_req(OP_INSERT,    3'd0, 16'h8000, 8'h00, 16'h0000);
      send_req(OP_INSERT,    3'd0, 16'h7FFF, 8'hFF, 16'h0000);
      send_req(OP_INSERT,    3'd0, 16'h0001, 8'hA5, 16'h0000);
      send_req(OP_READ_CHAR, 3'd0, 16'hFFFF, 8'h00, 16'h0000);
      send_req(OP_READ_CHAR, 3'd0, 16'h0003, 8'h00, 16'h0000);
      send_req(OP_READ_CHAR, 3'd0, 16'h0001, 8'h00, 16'h0000);
      send_req(OP_DELETE,    3'd0, 16'h0003, 8'h00, 16'h0000);
      send_req(OP_DELETE,    3'd0, 16'h8000, 8'h00, 16'h0000);
      send_req(OP_DELETE,    3'd0, 16'h0000, 8'h00, 16'h0000);
      // failed alloc drops the buffer but size still reports the old length
      send_req(OP_ALLOC,     3'd0, 16'h0000, 8'h00, 16'(MAX_LEN + 44));
      send_req(OP_SIZE,      3'd0, 16'h0000, 8'h00, 16'h0000);

      // one buffer filled to MAX_LEN, with more inserts than it holds
      id = BUF_ID_W'(NUM_BUFFERS - 1);
      send_req(OP_ALLOC, id, 16'h0000, 8'h00, 16'(MAX_LEN));
      repeat (MAX_LEN + 4) rand_req(OP_INSERT, id);
      repeat (12) send_req(OP_READ_CHAR, id, POSITION_W'($urandom_range(0, MAX_LEN + 8)),
                           CHAR_W'($urandom_range(0, 255)),
                           ALLOC_SIZE_W'($urandom_range(0, 65535)));
      send_req(OP_SIZE, id, 16'h0000, 8'h00, 16'h0000);
      repeat (6) rand_req(OP_DELETE, id);

      while (req_useful < REQ_TARGET) begin
         if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
         r  = $urandom_range(0, 99);
         id = pick_buf();
         if (r < 10) begin
            send_req(OP_ALLOC, id, pick_pos(), CHAR_W'($urandom_range(0, 255)), pick_size());
         end else if (r < 55) begin
            n = $urandom_range(3, 12);
            repeat (n) rand_req(OP_INSERT, id);
         end else if (r < 75) begin
            n = $urandom_range(2, 8);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0:       rand_req(OP_DELETE, id);
                  1:       rand_req(OP_SIZE, id);
                  default: rand_req(OP_READ_CHAR, id);
               endcase
            end
         end else if (r < 85) begin
            rand_req(($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_SIZE, id);
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) send_req(REQ_TYPE_W'($urandom_range(0, 7)),
                                BUF_ID_W'($urandom_range(0, 7)),
                                POSITION_W'($urandom_range(0, 65535)),
                                CHAR_W'($urandom_range(0, 255)),
                                ALLOC_SIZE_W'($urandom_range(0, 65535)));
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (MAX_LEN + 16) @(posedge clock);

      $display("Sent %0d requests (%0d to allocated-range buffers), checked %0d responses",
               req_sent, req_useful, rsp_count);
      $display("Ignored %0d, out of memory %0d, longest text %0d bytes",
               ignored_count, oom_count, peak_length);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
